[rtl/core/ratio_and_cross_check_match_filter_unit_macros.svh]
// assertion macros for the ratio and cross-check match filter
`ifndef RATIO_AND_CROSS_CHECK_MATCH_FILTER_UNIT_MACROS_SVH
`define RATIO_AND_CROSS_CHECK_MATCH_FILTER_UNIT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define RCCMF_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rccmf: same-cycle check failed");
// next-cycle implication
`define RCCMF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rccmf: next-cycle check failed");
`else
`define RCCMF_ASSERT_SAME(lbl, ante, cons)
`define RCCMF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[rtl/core/rccmf_pkg.sv]
// types and constants of the ratio and cross-check match filter
`timescale 1ns / 1ps
package rccmf_pkg;

    localparam int IDX_W     = 10;
    localparam int DIST_W    = 9;
    localparam int RATIO_W   = 9;
    localparam int IDX_RANGE = 1 << IDX_W;
    localparam int PROD_W    = DIST_W + RATIO_W;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_TEST  = 2'd2;

    localparam logic [0:0]         REG_RATIO   = 1'b0;
    localparam logic [RATIO_W-1:0] RATIO_RESET = 9'd204;

    typedef struct packed {
        logic [1:0]        operation;
        logic [IDX_W-1:0]  query_index;
        logic [IDX_W-1:0]  best_train_index;
        logic [DIST_W-1:0] best_distance;
        logic [DIST_W-1:0] second_distance;
    } t_in_item;

    typedef struct packed {
        logic              match_passes;
        logic [IDX_W-1:0]  out_query_index;
        logic [IDX_W-1:0]  out_train_index;
        logic [DIST_W-1:0] out_distance;
    } t_out_item;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] train_index;
    } t_entry;

endpackage

[rtl/core/rccmf_ram.sv]
// generic single-clock ram, one write port and one registered read port
`timescale 1ns / 1ps
module rccmf_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/ratio_and_cross_check_match_filter_unit.sv]
// top level of the ratio and cross-check match filter
`timescale 1ns / 1ps
// usage
//   input channel: i_in_valid / o_in_ready carry one match item (clear, load or test)
//   output channel: o_out_valid / i_out_ready carry one result item per input item
//   config: apb-style port, ratio_q8 at byte address 0, written in the access phase
//   throughput: one item per cycle for load and test items, back to back while no
//     sweep runs and results are taken; the table ram takes one write (load) and
//     one read (test) each cycle and a test that reads the entry written by the
//     load just ahead gets it forwarded
//   clear item: after it leaves the first stage a sweep zeroes the table ram,
//     one entry a cycle, over all min(MAX_KEYPOINTS, 1024) entries; no item
//     is taken meanwhile, config writes still are
//   reset: ratio_q8 returns to 204 and the same sweep runs before the first item
//   receiver stall: the result register holds; the first stage still holds one
//     item, after which o_in_ready falls until the result is taken
//   loads update the table without a read; tests read the entry at their train
//   index and check that it is valid and points back to their query index
module ratio_and_cross_check_match_filter_unit
    import rccmf_pkg::*;
#(
    parameter int MAX_KEYPOINTS = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // match items in
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in_item,
    // results out
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_item,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    // table only needs entries that a 10-bit index can reach
    localparam int DEPTH = (MAX_KEYPOINTS < IDX_RANGE) ? MAX_KEYPOINTS : IDX_RANGE;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    // configuration register
    logic [RATIO_W-1:0] r_ratio;
    logic [RATIO_W-1:0] n_ratio;
    logic               cfg_wr;
    logic               cfg_sel_ratio;

    // first stage, forwarding and output register
    logic      r_s1_valid, n_s1_valid;
    t_in_item  r_s1, n_s1;
    logic      r_fwd_hit, n_fwd_hit;
    logic [IDX_W-1:0] r_fwd_train, n_fwd_train;
    logic      r_out_valid, n_out_valid;
    t_out_item r_out, n_out;

    // clearing sweep
    logic          r_sweep, n_sweep;
    logic [AW-1:0] r_sweep_cnt, n_sweep_cnt;

    // datapath
    logic               in_accept;
    logic               s1_adv;
    logic               is_clear, is_load, is_test;
    logic [PROD_W-1:0]  s1_prod;
    logic [PROD_W-1:0]  s1_scaled;
    logic               ratio_ok;
    logic               q_in_range, t_in_range;
    logic               load_we;
    t_entry             rd_entry;
    t_entry             entry;
    logic               test_pass;

    // ram ports
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    t_entry        ram_wdata;

    // ---------------- configuration port ----------------
    assign pready        = 1'b1;
    assign cfg_wr        = psel && penable && pwrite && pready;
    assign cfg_sel_ratio = (paddr[2:2] == REG_RATIO);
    assign n_ratio       = (cfg_wr && cfg_sel_ratio) ? pwdata[RATIO_W-1:0] : r_ratio;
    assign prdata        = cfg_sel_ratio ? PDATA_W'(r_ratio) : '0;

    // ---------------- handshakes ----------------
    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    // a clear in the first stage holds the input back until its sweep is over
    assign o_in_ready = !r_sweep &&
                        (!r_s1_valid || (s1_adv && !is_clear));
    assign in_accept  = i_in_valid && o_in_ready;

    // ---------------- operation decode ----------------
    always_comb begin
        is_clear = 1'b0;
        is_load  = 1'b0;
        is_test  = 1'b0;
        unique case (r_s1.operation)
            OP_CLEAR: is_clear = 1'b1;
            OP_LOAD:  is_load  = 1'b1;
            OP_TEST:  is_test  = 1'b1;
            default: ;  // spare code: no table change, never passes
        endcase
    end

    // ratio test: best * 256 < second * ratio, exact
    assign s1_prod   = PROD_W'(r_s1.second_distance) * PROD_W'(r_ratio);
    assign s1_scaled = PROD_W'({r_s1.best_distance, 8'b0});
    assign ratio_ok  = s1_scaled < s1_prod;

    assign q_in_range = (32'(r_s1.query_index) < MAX_KEYPOINTS);
    assign t_in_range = (32'(r_s1.best_train_index) < MAX_KEYPOINTS);

    // a passing load writes its entry as it leaves the first stage
    assign load_we = s1_adv && is_load && q_in_range && ratio_ok;

    // forwarded entry overrides the stale ram read
    assign entry     = r_fwd_hit ? t_entry'{valid: 1'b1, train_index: r_fwd_train}
                                 : rd_entry;
    assign test_pass = is_test && t_in_range && ratio_ok && entry.valid &&
                       (entry.train_index == r_s1.query_index);

    // ---------------- table ram ----------------
    always_comb begin
        ram_we    = r_sweep || load_we;
        ram_waddr = r_sweep ? r_sweep_cnt : r_s1.query_index[AW-1:0];
        ram_wdata = r_sweep ? t_entry'('0)
                            : t_entry'{valid: 1'b1, train_index: r_s1.best_train_index};
    end

    rccmf_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_accept),
        .i_raddr (i_in_item.best_train_index[AW-1:0]),
        .o_rdata (rd_entry)
    );

    // ---------------- next state ----------------
    always_comb begin
        n_s1_valid  = r_s1_valid;
        n_s1        = r_s1;
        n_fwd_hit   = r_fwd_hit;
        n_fwd_train = r_fwd_train;
        if (in_accept) begin
            n_s1_valid  = 1'b1;
            n_s1        = i_in_item;
            // the load leaving now writes in the same edge as this read
            n_fwd_hit   = load_we && (i_in_item.operation == OP_TEST) &&
                          (i_in_item.best_train_index == r_s1.query_index);
            n_fwd_train = r_s1.best_train_index;
        end else if (s1_adv) begin
            n_s1_valid = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (s1_adv) begin
            n_out_valid           = 1'b1;
            n_out.match_passes    = test_pass;
            n_out.out_query_index = r_s1.query_index;
            n_out.out_train_index = r_s1.best_train_index;
            n_out.out_distance    = r_s1.best_distance;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_comb begin
        n_sweep     = r_sweep;
        n_sweep_cnt = r_sweep_cnt;
        if (r_sweep) begin
            n_sweep_cnt = r_sweep_cnt + AW'(1);
            if (r_sweep_cnt == LAST_ADDR) begin
                n_sweep     = 1'b0;
                n_sweep_cnt = '0;
            end
        end else if (s1_adv && is_clear) begin
            n_sweep     = 1'b1;
            n_sweep_cnt = '0;
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio     <= RATIO_RESET;
            r_s1_valid  <= 1'b0;
            r_fwd_hit   <= 1'b0;
            r_out_valid <= 1'b0;
            r_sweep     <= 1'b1;
            r_sweep_cnt <= '0;
        end else begin
            r_ratio     <= n_ratio;
            r_s1_valid  <= n_s1_valid;
            r_fwd_hit   <= n_fwd_hit;
            r_out_valid <= n_out_valid;
            r_sweep     <= n_sweep;
            r_sweep_cnt <= n_sweep_cnt;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_s1        <= n_s1;
        r_fwd_train <= n_fwd_train;
        r_out       <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // ---------------- assertions ----------------
`include "ratio_and_cross_check_match_filter_unit_macros.svh"

    // the sweep and a load never both claim the write port
    `RCCMF_ASSERT_SAME(a_no_write_clash, load_we, !r_sweep)
    // forwarding only ever serves a test item
    `RCCMF_ASSERT_SAME(a_fwd_test_only, r_s1_valid && r_fwd_hit, r_s1.operation == OP_TEST)
    // a sweep only starts once a clear item has left the first stage
    `RCCMF_ASSERT_NEXT(a_sweep_after_clear, !r_sweep && !(s1_adv && is_clear), !r_sweep)

endmodule
